@@ design/lsa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types, constants and the sine table of the scan analyser.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = 8;

    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [2:0] REG_STRENGTH_MIN   = 3'd0;
    localparam logic [2:0] REG_MAX_RANGE      = 3'd1;
    localparam logic [2:0] REG_FWD_ANGLE      = 3'd2;
    localparam logic [2:0] REG_Z_OFFSET       = 3'd3;
    localparam logic [2:0] REG_FRONT_HALF     = 3'd4;
    localparam logic [2:0] REG_FRONT_THRESH   = 3'd5;
    localparam logic [2:0] REG_TARGET_X       = 3'd6;

    localparam logic [15:0] STRENGTH_MIN_RST  = 16'd100;
    localparam logic [15:0] MAX_RANGE_RST     = 16'd800;
    localparam logic [7:0]  FWD_ANGLE_RST     = 8'd90;
    localparam logic [15:0] Z_OFFSET_RST      = 16'd0;
    localparam logic [7:0]  FRONT_HALF_RST    = 8'd30;
    localparam logic [15:0] FRONT_THRESH_RST  = 16'd50;
    localparam logic [20:0] TARGET_X_RST      = 21'd0;

    localparam logic [15:0] STRENGTH_SAT      = 16'hFFFF;
    localparam logic [30:0] ROUND_HALF        = 31'd512;

    typedef struct packed {
        logic [15:0]        strength_min;
        logic [15:0]        max_range_cm;
        logic [7:0]         fwd_angle;
        logic signed [15:0] z_offset;
        logic [7:0]         front_half_angle;
        logic [15:0]        front_threshold_cm;
        logic signed [20:0] target_x;
    } cfg_t;

    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } sin_t;

    // lookup stage result
    typedef struct packed {
        logic [15:0] dist_cm;
        logic [7:0]  servo;
        logic        ok;
        logic        last;
        logic        valid;
        logic        front_hit;
        logic [15:0] clr;
        sin_t        sx;
        sin_t        sz;
    } look_t;

    // multiply stage result
    typedef struct packed {
        logic [20:0] mx;
        logic [20:0] mz;
        logic        x_neg;
        logic        z_neg;
        logic        ok;
        logic        last;
        logic        valid;
        logic        front_hit;
        logic [15:0] clr;
        logic [15:0] dist_cm;
        logic [7:0]  servo;
    } mult_t;

    // coordinate stage result
    typedef struct packed {
        logic signed [20:0] x;
        logic signed [21:0] z;
        logic [21:0]        err;
        logic               last;
        logic               valid;
        logic               front_hit;
        logic [15:0]        clr;
        logic [15:0]        dist_cm;
        logic [7:0]         servo;
    } coord_t;

    // sin(k deg) * 2^14, k = 0..90
    function automatic logic [14:0] sine_rom(input logic [6:0] k);
        logic [14:0] v;
        case (k)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
            7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
            7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
            7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
            7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
            7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
            7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
            7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
            7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
            7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
            7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
            7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
            7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
            7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
            7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
            7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
            7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
            7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
            7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
            7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
            7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
            7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // sine of a whole-degree angle 0..359, folded onto the quarter table
    function automatic sin_t sin_lookup(input logic [8:0] a);
        logic [8:0] idx;
        sin_t       r;
        r.neg = 1'b0;
        if (a <= 9'd90) begin
            idx = a;
        end else if (a <= 9'd180) begin
            idx = 9'd180 - a;
        end else if (a <= 9'd270) begin
            idx   = a - 9'd180;
            r.neg = 1'b1;
        end else begin
            idx   = 9'd360 - a;
            r.neg = 1'b1;
        end
        r.mag = sine_rom(idx[6:0]);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/lsa_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_cfg_regs
// APB register bank holding the analyser configuration.
// ----------------------------------------------------------------------------
module lsa_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lsa_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lsa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lsa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output lsa_pkg::cfg_t                        cfg
);
    import lsa_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strength_min       <= STRENGTH_MIN_RST;
            cfg_reg.max_range_cm       <= MAX_RANGE_RST;
            cfg_reg.fwd_angle          <= FWD_ANGLE_RST;
            cfg_reg.z_offset           <= Z_OFFSET_RST;
            cfg_reg.front_half_angle   <= FRONT_HALF_RST;
            cfg_reg.front_threshold_cm <= FRONT_THRESH_RST;
            cfg_reg.target_x           <= TARGET_X_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STRENGTH_MIN: cfg_reg.strength_min       <= pwdata[15:0];
                REG_MAX_RANGE:    cfg_reg.max_range_cm       <= pwdata[15:0];
                REG_FWD_ANGLE:    cfg_reg.fwd_angle          <= pwdata[7:0];
                REG_Z_OFFSET:     cfg_reg.z_offset           <= pwdata[15:0];
                REG_FRONT_HALF:   cfg_reg.front_half_angle   <= pwdata[7:0];
                REG_FRONT_THRESH: cfg_reg.front_threshold_cm <= pwdata[15:0];
                REG_TARGET_X:     cfg_reg.target_x           <= pwdata[20:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STRENGTH_MIN: prdata = {16'd0, cfg_reg.strength_min};
            REG_MAX_RANGE:    prdata = {16'd0, cfg_reg.max_range_cm};
            REG_FWD_ANGLE:    prdata = {24'd0, cfg_reg.fwd_angle};
            REG_Z_OFFSET:     prdata = {{16{cfg_reg.z_offset[15]}}, cfg_reg.z_offset};
            REG_FRONT_HALF:   prdata = {24'd0, cfg_reg.front_half_angle};
            REG_FRONT_THRESH: prdata = {16'd0, cfg_reg.front_threshold_cm};
            REG_TARGET_X:     prdata = {{11{cfg_reg.target_x[20]}}, cfg_reg.target_x};
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/lsa_lookup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_lookup
// Input register, then validity checks, beam angle and sine/cosine lookup.
// ----------------------------------------------------------------------------
module lsa_lookup (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lsa_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [15:0]    distance_cm,
    input  wire logic [15:0]    strength,
    input  wire logic [7:0]     servo_angle,
    input  wire logic           read_ok,
    input  wire logic           last_in_scan,
    output logic                lk_valid,
    output lsa_pkg::look_t      lk,
    input  wire logic           dn_ready
);
    import lsa_pkg::*;

    logic        v0_reg;
    logic [15:0] dist_reg;
    logic [15:0] str_reg;
    logic [7:0]  servo_reg;
    logic        ok_reg;
    logic        last_reg;
    logic        v1_reg;
    look_t       lk_reg;
    look_t       lk_next;
    logic        ready0;
    logic        ready1;

    logic signed [9:0] beam;
    logic [9:0]        a_wide;
    logic [9:0]        ac_wide;
    logic [9:0]        absb;
    logic              sector;

    assign ready1   = !v1_reg || dn_ready;
    assign ready0   = !v0_reg || ready1;
    assign in_stall = !ready0;
    assign lk_valid = v1_reg;
    assign lk       = lk_reg;

    always_comb
    begin
        beam    = $signed({2'b00, servo_reg}) - $signed({2'b00, cfg.fwd_angle});
        a_wide  = beam[9] ? 10'($unsigned(beam) + 10'd360) : $unsigned(beam);
        ac_wide = (a_wide + 10'd90 >= 10'd360) ? a_wide + 10'd90 - 10'd360
                                               : a_wide + 10'd90;
        absb    = beam[9] ? $unsigned(-beam) : $unsigned(beam);
        sector  = absb <= {2'b00, cfg.front_half_angle};

        lk_next.dist_cm = dist_reg;
        lk_next.servo   = servo_reg;
        lk_next.ok      = ok_reg;
        lk_next.last    = last_reg;
        lk_next.valid = ok_reg && (str_reg >= cfg.strength_min) && (str_reg != STRENGTH_SAT)
                        && (dist_reg != 16'd0) && (dist_reg <= cfg.max_range_cm);
        lk_next.front_hit = lk_next.valid && sector
                            && (dist_reg <= cfg.front_threshold_cm);
        lk_next.clr   = lk_next.valid ? dist_reg : cfg.max_range_cm;
        lk_next.sx    = sin_lookup(a_wide[8:0]);
        lk_next.sz    = sin_lookup(ac_wide[8:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                v0_reg <= in_valid;
            end
            if (ready1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && in_valid)
        begin
            dist_reg  <= distance_cm;
            str_reg   <= strength;
            servo_reg <= servo_angle;
            ok_reg    <= read_ok;
            last_reg  <= last_in_scan;
        end
        if (ready1 && v0_reg)
        begin
            lk_reg <= lk_next;
        end
    end

endmodule
`default_nettype wire

@@ design/lsa_coord.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_coord
// Distance times sine/cosine with rounding, then signed X/Z and X error.
// ----------------------------------------------------------------------------
module lsa_coord (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lsa_pkg::cfg_t  cfg,
    input  wire logic           lk_valid,
    input  wire lsa_pkg::look_t lk,
    output logic                up_ready,
    output logic                cd_valid,
    output lsa_pkg::coord_t     cd,
    input  wire logic           dn_ready
);
    import lsa_pkg::*;

    logic   v2_reg;
    logic   v3_reg;
    mult_t  mu_reg;
    mult_t  mu_next;
    coord_t cd_reg;
    coord_t cd_next;
    logic   ready2;
    logic   ready3;

    logic [30:0]        px;
    logic [30:0]        pz;
    logic signed [21:0] x_w;
    logic signed [22:0] z_w;
    logic signed [22:0] e_w;
    logic signed [20:0] x_s;

    assign ready3   = !v3_reg || dn_ready;
    assign ready2   = !v2_reg || ready3;
    assign up_ready = ready2;
    assign cd_valid = v3_reg;
    assign cd       = cd_reg;

    always_comb
    begin
        px = 31'(lk.dist_cm) * 31'(lk.sx.mag) + ROUND_HALF;
        pz = 31'(lk.dist_cm) * 31'(lk.sz.mag) + ROUND_HALF;
        mu_next.mx        = px[30:10];
        mu_next.mz        = pz[30:10];
        mu_next.x_neg     = lk.sx.neg;
        mu_next.z_neg     = lk.sz.neg;
        mu_next.ok        = lk.ok;
        mu_next.last      = lk.last;
        mu_next.valid     = lk.valid;
        mu_next.front_hit = lk.front_hit;
        mu_next.clr       = lk.clr;
        mu_next.dist_cm   = lk.dist_cm;
        mu_next.servo     = lk.servo;
    end

    always_comb
    begin
        x_w = mu_reg.x_neg ? -$signed({1'b0, mu_reg.mx}) : $signed({1'b0, mu_reg.mx});
        z_w = (mu_reg.z_neg ? -$signed({2'b00, mu_reg.mz}) : $signed({2'b00, mu_reg.mz}))
              - 23'(cfg.z_offset);
        x_s = mu_reg.ok ? x_w[20:0] : 21'sd0;
        e_w = 23'(x_s) - 23'(cfg.target_x);

        cd_next.x         = x_s;
        cd_next.z         = mu_reg.ok ? z_w[21:0] : 22'sd0;
        cd_next.err       = e_w[22] ? 22'($unsigned(-e_w)) : 22'($unsigned(e_w));
        cd_next.last      = mu_reg.last;
        cd_next.valid     = mu_reg.valid;
        cd_next.front_hit = mu_reg.front_hit;
        cd_next.clr       = mu_reg.clr;
        cd_next.dist_cm   = mu_reg.dist_cm;
        cd_next.servo     = mu_reg.servo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                v2_reg <= lk_valid;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && lk_valid)
        begin
            mu_reg <= mu_next;
        end
        if (ready3 && v2_reg)
        begin
            cd_reg <= cd_next;
        end
    end

endmodule
`default_nettype wire

@@ design/lsa_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_tracker
// Running scan results and the result register.
// ----------------------------------------------------------------------------
module lsa_tracker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsa_pkg::cfg_t   cfg,
    input  wire logic            cd_valid,
    input  wire lsa_pkg::coord_t cd,
    output logic                 up_ready,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic signed [20:0]   x_pos,
    output logic signed [21:0]   z_pos,
    output logic                 sample_valid,
    output logic [7:0]           nearest_index,
    output logic                 nearest_found,
    output logic [7:0]           clearest_angle,
    output logic                 obstacle_ahead,
    output logic [7:0]           closest_x_angle,
    output logic                 closest_x_found,
    output logic                 scan_done
);
    import lsa_pkg::*;

    logic [COUNT_W-1:0] cnt_reg,        cnt_next;
    logic [IDX_W-1:0]   near_idx_reg,   near_idx_next;
    logic [15:0]        near_dist_reg,  near_dist_next;
    logic               near_seen_reg,  near_seen_next;
    logic [15:0]        clear_val_reg,  clear_val_next;
    logic [7:0]         clear_ang_reg,  clear_ang_next;
    logic               clear_seen_reg, clear_seen_next;
    logic               ahead_reg,      ahead_next;
    logic [21:0]        x_err_reg,      x_err_next;
    logic [7:0]         x_ang_reg,      x_ang_next;
    logic               x_seen_reg,     x_seen_next;
    logic               out_valid_reg;
    logic               load;
    logic               cap;

    assign up_ready  = !out_valid_reg || !out_stall;
    assign load      = up_ready && cd_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cap             = cnt_reg < COUNT_W'(MAX_SAMPLES);
        cnt_next        = cap ? cnt_reg + 1'b1 : cnt_reg;
        near_idx_next   = near_idx_reg;
        near_dist_next  = near_dist_reg;
        near_seen_next  = near_seen_reg;
        clear_val_next  = clear_val_reg;
        clear_ang_next  = clear_ang_reg;
        clear_seen_next = clear_seen_reg;
        ahead_next      = ahead_reg;
        x_err_next      = x_err_reg;
        x_ang_next      = x_ang_reg;
        x_seen_next     = x_seen_reg;

        if (cap)
        begin
            if (cd.valid && (!near_seen_reg || cd.dist_cm < near_dist_reg))
            begin
                near_dist_next = cd.dist_cm;
                near_idx_next  = IDX_W'(cnt_reg);
                near_seen_next = 1'b1;
            end
            if (!clear_seen_reg || cd.clr > clear_val_reg)
            begin
                clear_val_next  = cd.clr;
                clear_ang_next  = cd.servo;
                clear_seen_next = 1'b1;
            end
            if (cd.front_hit)
            begin
                ahead_next = 1'b1;
            end
            if (cd.valid && (!x_seen_reg || cd.err < x_err_reg))
            begin
                x_err_next  = cd.err;
                x_ang_next  = cd.servo;
                x_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            near_idx_reg   <= '0;
            near_dist_reg  <= '0;
            near_seen_reg  <= 1'b0;
            clear_val_reg  <= '0;
            clear_ang_reg  <= '0;
            clear_seen_reg <= 1'b0;
            ahead_reg      <= 1'b0;
            x_err_reg      <= '0;
            x_ang_reg      <= '0;
            x_seen_reg     <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                out_valid_reg <= cd_valid;
            end
            if (load && cd.last)
            begin
                cnt_reg        <= '0;
                near_idx_reg   <= '0;
                near_dist_reg  <= '0;
                near_seen_reg  <= 1'b0;
                clear_val_reg  <= '0;
                clear_ang_reg  <= '0;
                clear_seen_reg <= 1'b0;
                ahead_reg      <= 1'b0;
                x_err_reg      <= '0;
                x_ang_reg      <= '0;
                x_seen_reg     <= 1'b0;
            end
            else if (load)
            begin
                cnt_reg        <= cnt_next;
                near_idx_reg   <= near_idx_next;
                near_dist_reg  <= near_dist_next;
                near_seen_reg  <= near_seen_next;
                clear_val_reg  <= clear_val_next;
                clear_ang_reg  <= clear_ang_next;
                clear_seen_reg <= clear_seen_next;
                ahead_reg      <= ahead_next;
                x_err_reg      <= x_err_next;
                x_ang_reg      <= x_ang_next;
                x_seen_reg     <= x_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_pos           <= cd.x;
            z_pos           <= cd.z;
            sample_valid    <= cd.valid;
            nearest_index   <= near_seen_next ? near_idx_next : '0;
            nearest_found   <= near_seen_next;
            clearest_angle  <= clear_seen_next ? clear_ang_next : cfg.fwd_angle;
            obstacle_ahead  <= ahead_next;
            closest_x_angle <= x_seen_next ? x_ang_next : '0;
            closest_x_found <= x_seen_next;
            scan_done       <= cd.last;
        end
    end

endmodule
`default_nettype wire

@@ design/lidar_scan_analyzer.sv @@
`default_nettype none
// Throughput: one sample per cycle while out_stall does not hold the pipeline;
// five register stages (input, lookup, multiply, coordinates, result) each
// hold one transfer.
// Reset: asynchronous, active low; clears the pipeline, the scan summary
// and loads the register defaults.
// ----------------------------------------------------------------------------
// lidar_scan_analyzer
// Rangefinder scan analyser: sample validity, X/Z coordinates and running
// nearest, clearest, front obstacle and closest-X results per scan.
// ----------------------------------------------------------------------------
module lidar_scan_analyzer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lsa_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lsa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lsa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [15:0]                     distance_cm,
    input  wire logic [15:0]                     strength,
    input  wire logic [7:0]                      servo_angle,
    input  wire logic                            read_ok,
    input  wire logic                            last_in_scan,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [20:0]                   x_pos,
    output logic signed [21:0]                   z_pos,
    output logic                                 sample_valid,
    output logic [7:0]                           nearest_index,
    output logic                                 nearest_found,
    output logic [7:0]                           clearest_angle,
    output logic                                 obstacle_ahead,
    output logic [7:0]                           closest_x_angle,
    output logic                                 closest_x_found,
    output logic                                 scan_done
);
    import lsa_pkg::*;

    cfg_t   cfg;
    look_t  lk;
    coord_t cd;
    logic   lk_valid;
    logic   lk_ready;
    logic   cd_valid;
    logic   cd_ready;

    lsa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsa_lookup u_lookup (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .distance_cm  (distance_cm),
        .strength     (strength),
        .servo_angle  (servo_angle),
        .read_ok      (read_ok),
        .last_in_scan (last_in_scan),
        .lk_valid     (lk_valid),
        .lk           (lk),
        .dn_ready     (lk_ready)
    );

    lsa_coord u_coord (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .lk_valid (lk_valid),
        .lk       (lk),
        .up_ready (lk_ready),
        .cd_valid (cd_valid),
        .cd       (cd),
        .dn_ready (cd_ready)
    );

    lsa_tracker u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cd_valid        (cd_valid),
        .cd              (cd),
        .up_ready        (cd_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_pos           (x_pos),
        .z_pos           (z_pos),
        .sample_valid    (sample_valid),
        .nearest_index   (nearest_index),
        .nearest_found   (nearest_found),
        .clearest_angle  (clearest_angle),
        .obstacle_ahead  (obstacle_ahead),
        .closest_x_angle (closest_x_angle),
        .closest_x_found (closest_x_found),
        .scan_done       (scan_done)
    );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scans of rangefinder samples into lidar_scan_analyzer under random
// sender gaps and receiver stalls, predicts every result transfer and checks
// it field by field, and writes and reads back all registers between phases.
// ----------------------------------------------------------------------------

// sin(k deg) * 2^14, k = 0..90
localparam int SINE_Q14 [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
};

typedef struct {
    logic [15:0] dist_cm;
    logic [15:0] str;
    logic [7:0]  servo;
    logic        ok;
    logic        last;
} lidar_sample_t;

typedef struct {
    logic signed [20:0] x_pos;
    logic signed [21:0] z_pos;
    logic               sample_valid;
    logic [7:0]         nearest_index;
    logic               nearest_found;
    logic [7:0]         clearest_angle;
    logic               obstacle_ahead;
    logic [7:0]         closest_x_angle;
    logic               closest_x_found;
    logic               scan_done;
} scan_result_t;

class scan_scoreboard;
    int unsigned strength_min, max_range_cm, fwd_angle, front_half, front_thresh;
    int          z_offset, target_x;

    int unsigned count, near_idx, near_dist, clear_val, clear_ang, x_err, x_ang;
    bit          near_seen, clear_seen, ahead, x_seen;

    scan_result_t awaited[$];
    int failures, n_samples, n_scans, n_valid, n_over;

    function new();
        strength_min = lsa_pkg::STRENGTH_MIN_RST;
        max_range_cm = lsa_pkg::MAX_RANGE_RST;
        fwd_angle    = lsa_pkg::FWD_ANGLE_RST;
        z_offset     = $signed(lsa_pkg::Z_OFFSET_RST);
        front_half   = lsa_pkg::FRONT_HALF_RST;
        front_thresh = lsa_pkg::FRONT_THRESH_RST;
        target_x     = $signed(lsa_pkg::TARGET_X_RST);
        clear_scan();
    endfunction

    function void clear_scan();
        count = 0; near_idx = 0; near_dist = 0; near_seen = 0;
        clear_val = 0; clear_ang = 0; clear_seen = 0; ahead = 0;
        x_err = 0; x_ang = 0; x_seen = 0;
    endfunction

    function logic [31:0] field_mask(logic [2:0] idx);
        case (idx)
            lsa_pkg::REG_FWD_ANGLE, lsa_pkg::REG_FRONT_HALF: return 32'hFF;
            lsa_pkg::REG_TARGET_X:                            return 32'h1F_FFFF;
            default:                                          return 32'hFFFF;
        endcase
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            lsa_pkg::REG_STRENGTH_MIN: strength_min = v[15:0];
            lsa_pkg::REG_MAX_RANGE:    max_range_cm = v[15:0];
            lsa_pkg::REG_FWD_ANGLE:    fwd_angle    = v[7:0];
            lsa_pkg::REG_Z_OFFSET:     z_offset     = $signed(v[15:0]);
            lsa_pkg::REG_FRONT_HALF:   front_half   = v[7:0];
            lsa_pkg::REG_FRONT_THRESH: front_thresh = v[15:0];
            lsa_pkg::REG_TARGET_X:     target_x     = $signed(v[20:0]);
            default: ;
        endcase
    endfunction

    // signed Q14 sine of a whole-degree angle in 0..359
    function int sine_of(int a);
        if (a <= 90)  return SINE_Q14[a];
        if (a <= 180) return SINE_Q14[180 - a];
        if (a <= 270) return -SINE_Q14[a - 180];
        return -SINE_Q14[360 - a];
    endfunction

    // cm times Q14 sine -> 1/16 cm, half away from zero
    function longint fixed_mul(int unsigned d, int s);
        longint m, mag;
        m   = (s < 0) ? -s : s;
        mag = (longint'(d) * m + 512) >>> 10;
        return (s < 0) ? -mag : mag;
    endfunction

    function void note_sample(lidar_sample_t s);
        int           beam, a, ac;
        longint       x, z, e;
        int unsigned  absb, clr, ue;
        bit           valid;
        scan_result_t r;
        beam  = int'(s.servo) - int'(fwd_angle);
        a     = (beam < 0) ? beam + 360 : beam;
        ac    = (a + 90 >= 360) ? a - 270 : a + 90;
        x     = 0;
        z     = 0;
        valid = 0;
        if (s.ok) begin
            x     = fixed_mul(s.dist_cm, sine_of(a));
            z     = fixed_mul(s.dist_cm, sine_of(ac)) - z_offset;
            valid = s.str >= strength_min && s.str != lsa_pkg::STRENGTH_SAT
                    && s.dist_cm != 0 && s.dist_cm <= max_range_cm;
        end
        n_samples++;
        if (valid) n_valid++;
        if (count < lsa_pkg::MAX_SAMPLES) begin
            clr  = valid ? s.dist_cm : max_range_cm;
            absb = (beam < 0) ? -beam : beam;
            if (valid && (!near_seen || s.dist_cm < near_dist)) begin
                near_dist = s.dist_cm; near_idx = count & 8'hFF; near_seen = 1;
            end
            if (!clear_seen || clr > clear_val) begin
                clear_val = clr; clear_ang = s.servo; clear_seen = 1;
            end
            if (valid && absb <= front_half && s.dist_cm <= front_thresh)
                ahead = 1;
            if (valid) begin
                e  = x - target_x;
                ue = (e < 0) ? -e : e;
                if (!x_seen || ue < x_err) begin
                    x_err = ue; x_ang = s.servo; x_seen = 1;
                end
            end
            count++;
        end else begin
            n_over++;
        end
        r.x_pos           = x[20:0];
        r.z_pos           = z[21:0];
        r.sample_valid    = valid;
        r.nearest_index   = near_seen ? near_idx[7:0] : 8'd0;
        r.nearest_found   = near_seen;
        r.clearest_angle  = clear_seen ? clear_ang[7:0] : fwd_angle[7:0];
        r.obstacle_ahead  = ahead;
        r.closest_x_angle = x_seen ? x_ang[7:0] : 8'd0;
        r.closest_x_found = x_seen;
        r.scan_done       = s.last;
        awaited.push_back(r);
        if (s.last) begin
            n_scans++;
            clear_scan();
        end
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(scan_result_t got);
        scan_result_t want;
        if (awaited.size() == 0) begin
            $error("result transfer with no sample outstanding");
            failures++;
            return;
        end
        want = awaited.pop_front();
        check_field("x_pos", want.x_pos, got.x_pos);
        check_field("z_pos", want.z_pos, got.z_pos);
        check_field("sample_valid", want.sample_valid, got.sample_valid);
        check_field("nearest_index", want.nearest_index, got.nearest_index);
        check_field("nearest_found", want.nearest_found, got.nearest_found);
        check_field("clearest_angle", want.clearest_angle, got.clearest_angle);
        check_field("obstacle_ahead", want.obstacle_ahead, got.obstacle_ahead);
        check_field("closest_x_angle", want.closest_x_angle, got.closest_x_angle);
        check_field("closest_x_found", want.closest_x_found, got.closest_x_found);
        check_field("scan_done", want.scan_done, got.scan_done);
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT = 400000;

    logic                             clk;
    logic                             rst_n        = 1'b0;
    logic                             psel         = 1'b0;
    logic                             penable      = 1'b0;
    logic                             pwrite       = 1'b0;
    logic [lsa_pkg::APB_ADDR_W-1:0]   paddr        = '0;
    logic [lsa_pkg::APB_DATA_W-1:0]   pwdata       = '0;
    logic [lsa_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             in_valid     = 1'b0;
    logic                             in_stall;
    logic [15:0]                      distance_cm  = '0;
    logic [15:0]                      strength     = '0;
    logic [7:0]                       servo_angle  = '0;
    logic                             read_ok      = 1'b0;
    logic                             last_in_scan = 1'b0;
    logic                             out_valid;
    logic                             out_stall    = 1'b0;
    logic signed [20:0]               x_pos;
    logic signed [21:0]               z_pos;
    logic                             sample_valid;
    logic [7:0]                       nearest_index;
    logic                             nearest_found;
    logic [7:0]                       clearest_angle;
    logic                             obstacle_ahead;
    logic [7:0]                       closest_x_angle;
    logic                             closest_x_found;
    logic                             scan_done;

    scan_scoreboard sb;
    lidar_sample_t  seen_sample;
    scan_result_t   seen_result;
    int             in_idle_pct;
    int             out_stall_pct;
    int             n_writes;
    int             cycle_count;

    lidar_scan_analyzer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .distance_cm     (distance_cm),
        .strength        (strength),
        .servo_angle     (servo_angle),
        .read_ok         (read_ok),
        .last_in_scan    (last_in_scan),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_pos           (x_pos),
        .z_pos           (z_pos),
        .sample_valid    (sample_valid),
        .nearest_index   (nearest_index),
        .nearest_found   (nearest_found),
        .clearest_angle  (clearest_angle),
        .obstacle_ahead  (obstacle_ahead),
        .closest_x_angle (closest_x_angle),
        .closest_x_found (closest_x_found),
        .scan_done       (scan_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);

    // transfers are observed on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen_sample.dist_cm = distance_cm;
                seen_sample.str     = strength;
                seen_sample.servo   = servo_angle;
                seen_sample.ok      = read_ok;
                seen_sample.last    = last_in_scan;
                sb.note_sample(seen_sample);
            end
            if (out_valid && !out_stall)
            begin
                seen_result.x_pos           = x_pos;
                seen_result.z_pos           = z_pos;
                seen_result.sample_valid    = sample_valid;
                seen_result.nearest_index   = nearest_index;
                seen_result.nearest_found   = nearest_found;
                seen_result.clearest_angle  = clearest_angle;
                seen_result.obstacle_ahead  = obstacle_ahead;
                seen_result.closest_x_angle = closest_x_angle;
                seen_result.closest_x_found = closest_x_found;
                seen_result.scan_done       = scan_done;
                sb.check_result(seen_result);
            end
        end
    end

    task automatic send_sample(logic [15:0] d, logic [15:0] s, logic [7:0] a,
                               logic ok, logic last);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        distance_cm  <= d;
        strength     <= s;
        servo_angle  <= a;
        read_ok      <= ok;
        last_in_scan <= last;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        logic [31:0] mask;
        mask     = sb.field_mask(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value & mask;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        n_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) != (value & mask))
        begin
            $error("register %0d read-back: expected %0h, got %0h",
                   idx, value & mask, prdata & mask);
            sb.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(logic [31:0] smin, logic [31:0] maxr, logic [31:0] centre,
                                logic [31:0] zoff, logic [31:0] half, logic [31:0] thresh,
                                logic [31:0] target);
        drain();
        cfg_write(lsa_pkg::REG_STRENGTH_MIN, smin);
        cfg_write(lsa_pkg::REG_MAX_RANGE, maxr);
        cfg_write(lsa_pkg::REG_FWD_ANGLE, centre);
        cfg_write(lsa_pkg::REG_Z_OFFSET, zoff);
        cfg_write(lsa_pkg::REG_FRONT_HALF, half);
        cfg_write(lsa_pkg::REG_FRONT_THRESH, thresh);
        cfg_write(lsa_pkg::REG_TARGET_X, target);
    endtask

    task automatic random_setup();
        int unsigned maxr;
        int          target;
        maxr   = $urandom_range(3000, 200);
        target = int'($urandom_range(maxr * 32)) - int'(maxr * 16);
        apply_config($urandom_range(300), maxr, $urandom_range(120, 60), $urandom_range(65535),
                     $urandom_range(60), $urandom_range(300, 20), target);
    endtask

    // mostly well-formed sweeps; some noise transfers with stray scan ends
    task automatic run_scans(int n_items, bit with_long);
        int          sent, len, step, base;
        bit          first;
        int unsigned maxr, smin;
        logic [15:0] d, s;
        logic [7:0]  a;
        logic        ok, last;
        sent  = 0;
        first = 1'b1;
        while (sent < n_items)
        begin
            if (with_long && first)
                len = $urandom_range(300, 257);
            else if ($urandom_range(99) < 10)
                len = $urandom_range(120, 60);
            else
                len = $urandom_range(40, 1);
            first = 1'b0;
            step  = $urandom_range(12, 1);
            base  = $urandom_range(180);
            for (int i = 0; i < len; i++)
            begin
                maxr = (sb.max_range_cm == 0) ? 1 : sb.max_range_cm;
                smin = (sb.strength_min > 65534) ? 65534 : sb.strength_min;
                if ($urandom_range(99) < 8)
                begin
                    d    = 16'($urandom);
                    s    = 16'($urandom);
                    a    = 8'($urandom_range(180));
                    ok   = 1'($urandom);
                    last = ($urandom_range(99) < 5);
                end
                else
                begin
                    case ($urandom_range(9))
                        0:       d = 16'($urandom_range(sb.front_thresh + 10));
                        1:       d = 16'($urandom);
                        default: d = 16'($urandom_range(maxr, 1));
                    endcase
                    case ($urandom_range(19))
                        0:       s = lsa_pkg::STRENGTH_SAT;
                        1, 2:    s = 16'($urandom);
                        default: s = 16'($urandom_range(65534, smin));
                    endcase
                    a    = ($urandom_range(3) == 0) ? 8'($urandom_range(180))
                                                    : 8'((base + i * step) % 181);
                    ok   = ($urandom_range(99) < 93);
                    last = (i == len - 1);
                end
                send_sample(d, s, a, ok, last);
            end
            sent += len;
        end
    endtask

    initial
    begin
        sb            = new();
        in_idle_pct   = 18;
        out_stall_pct = 58;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        send_sample(16'd500, 16'd1000, 8'd90, 1'b0, 1'b0);
        send_sample(16'd0, 16'd1000, 8'd45, 1'b1, 1'b0);
        send_sample(16'd801, 16'd1000, 8'd135, 1'b1, 1'b0);
        send_sample(16'd800, 16'd100, 8'd0, 1'b1, 1'b0);
        send_sample(16'd300, 16'd99, 8'd180, 1'b1, 1'b0);
        send_sample(16'd300, 16'hFFFF, 8'd180, 1'b1, 1'b0);
        send_sample(16'd300, 16'hFFFE, 8'd180, 1'b1, 1'b0);
        send_sample(16'd50, 16'd500, 8'd60, 1'b1, 1'b0);
        send_sample(16'd51, 16'd500, 8'd120, 1'b1, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 8'd128, 1'b1, 1'b0);
        send_sample(16'd1, 16'd200, 8'd91, 1'b1, 1'b1);
        send_sample(16'hFFFF, 16'hFFFF, 8'd180, 1'b0, 1'b0);
        send_sample(16'd10, 16'd5, 8'd90, 1'b1, 1'b1);
        send_sample(16'd20, 16'd300, 8'd90, 1'b1, 1'b1);
        for (int k = 0; k <= 6; k++)
            send_sample(16'd700, 16'd400, 8'(k * 30), 1'b1, k == 6);
        send_sample(16'd0, 16'd0, 8'd0, 1'b0, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 8'd180, 1'b1, 1'b1);

        random_setup();
        run_scans(350, 1'b1);
        apply_config(32'd0, 32'd65535, 32'd0, 32'h8000, 32'd180, 32'd65535, 32'h10_0000);
        run_scans(120, 1'b0);

        in_idle_pct   = 58;
        out_stall_pct = 18;
        random_setup();
        run_scans(350, 1'b1);
        apply_config(32'd65535, 32'd0, 32'd180, 32'h7FFF, 32'd0, 32'd0, 32'h0F_FFFF);
        run_scans(100, 1'b0);

        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_setup();
        run_scans(500, 1'b1);

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.failures++;
        end
        $display("Checked %0d samples in %0d closed scans: %0d valid, %0d past scan capacity.",
                 sb.n_samples, sb.n_scans, sb.n_valid, sb.n_over);
        $display("%0d register writes with read-back; idling on either side, both, then none.",
                 n_writes);
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
design/lsa_pkg.sv
design/lsa_cfg_regs.sv
design/lsa_lookup.sv
design/lsa_coord.sv
design/lsa_tracker.sv
design/lidar_scan_analyzer.sv
tb/testbench.sv
